// File: hw/rtl/jch_pkg.sv
`default_nettype none

package jch_pkg;

    // Field widths of the ports.
    localparam int KEY_W       = 64;
    localparam int BUCKET_W    = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 1;

    // Fixed shifts of the jump step: j = ((b + 1) << FRAC_SHIFT) / ((key >> KEY_SHIFT) + 1).
    localparam int FRAC_SHIFT  = 31;
    localparam int KEY_SHIFT   = 33;
    localparam int HALF_W      = KEY_W / 2;
    localparam int DVS_W       = KEY_W - KEY_SHIFT + 1;

    localparam int BUCKET_BITS_DEF = 32;

    localparam logic [KEY_W-1:0]    MULT_RESET  = 64'd2862933555777941757;
    localparam logic [BUCKET_W-1:0] COUNT_RESET = 32'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUCKET_COUNT = 1'b0,
        CFG_LCG_MULT     = 1'b1
    } t_cfg_idx;

    // Operand halves fed to the shared 32x32 multiplier.
    typedef enum logic [1:0] {
        MUL_LO_LO,
        MUL_LO_HI,
        MUL_HI_LO
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD_HI
    } t_acc_op;

    typedef struct packed {
        logic     key_load;
        logic     key_update;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     div_init;
        logic     div_step;
        logic     b_load;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic div_last;
        logic more;
    } t_dp_status;

endpackage

`default_nettype wire

// File: hw/rtl/jch_datapath.sv
`default_nettype none

module jch_datapath #(
    parameter int BUCKET_BITS = jch_pkg::BUCKET_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic [jch_pkg::KEY_W-1:0] i_key,
    input  wire logic [jch_pkg::KEY_W-1:0] i_mult,
    input  wire logic [BUCKET_BITS-1:0]    i_count,
    input  wire jch_pkg::t_dp_cmd          i_cmd,
    output jch_pkg::t_dp_status            o_status,
    output logic [BUCKET_BITS-1:0]         o_bucket
);
    import jch_pkg::*;

    localparam int DIV_STEPS = BUCKET_BITS + FRAC_SHIFT;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    logic [KEY_W-1:0]       r_key;
    logic [KEY_W-1:0]       r_pp;
    logic [KEY_W-1:0]       r_acc;
    logic [BUCKET_BITS-1:0] r_b;
    logic [DVS_W-1:0]       r_dvs;
    logic [DVS_W-2:0]       r_rem;
    logic [BUCKET_BITS-1:0] r_dvd;
    logic [BUCKET_BITS-1:0] r_q;
    logic                   r_ovf;
    logic [CNT_W-1:0]       r_cnt;

    logic [HALF_W-1:0]      mul_a;
    logic [HALF_W-1:0]      mul_b;
    logic [DVS_W-1:0]       rem_sh;
    logic                   rem_ge;
    logic [DVS_W-1:0]       rem_diff;
    logic [BUCKET_BITS:0]   q_sh;
    logic [BUCKET_BITS:0]   dvd_sh;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_LO_LO: begin
                mul_a = r_key[HALF_W-1:0];
                mul_b = i_mult[HALF_W-1:0];
            end
            MUL_LO_HI: begin
                mul_a = r_key[HALF_W-1:0];
                mul_b = i_mult[KEY_W-1:HALF_W];
            end
            MUL_HI_LO: begin
                mul_a = r_key[KEY_W-1:HALF_W];
                mul_b = i_mult[HALF_W-1:0];
            end
            default: begin
                mul_a = r_key[HALF_W-1:0];
                mul_b = i_mult[HALF_W-1:0];
            end
        endcase
    end

    // One restoring division step: bring down the next dividend bit.
    assign rem_sh   = {r_rem, r_dvd[BUCKET_BITS-1]};
    assign rem_ge   = (rem_sh >= r_dvs);
    assign rem_diff = rem_sh - r_dvs;
    assign q_sh     = {r_q, rem_ge};
    assign dvd_sh   = {r_dvd, 1'b0};

    always_ff @(posedge i_clk) begin
        r_pp <= KEY_W'(mul_a) * KEY_W'(mul_b);

        case (i_cmd.acc_op)
            ACC_LOAD:   r_acc <= r_pp;
            ACC_ADD_HI: r_acc <= r_acc + {r_pp[HALF_W-1:0], {HALF_W{1'b0}}};
            default:    r_acc <= r_acc;
        endcase

        if (i_cmd.key_load) begin
            r_key <= i_key;
            r_b   <= '0;
        end else if (i_cmd.key_update) begin
            r_key <= r_acc + KEY_W'(1);
        end

        if (i_cmd.b_load) begin
            r_b <= r_q;
        end

        if (i_cmd.div_init) begin
            r_dvs <= DVS_W'(r_key[KEY_W-1:KEY_SHIFT]) + DVS_W'(1);
            r_rem <= '0;
            r_dvd <= r_b + BUCKET_BITS'(1);
            r_q   <= '0;
            r_ovf <= 1'b0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_diff[DVS_W-2:0] : rem_sh[DVS_W-2:0];
            r_dvd <= dvd_sh[BUCKET_BITS-1:0];
            r_q   <= q_sh[BUCKET_BITS-1:0];
            r_ovf <= r_ovf | q_sh[BUCKET_BITS];
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    assign o_status.count_zero = (i_count == '0);
    assign o_status.div_last   = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_status.more       = !r_ovf && (r_q < i_count);
    assign o_bucket            = r_b;

endmodule

`default_nettype wire

// File: hw/rtl/jch_ctrl.sv
`default_nettype none

module jch_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_out_free,
    input  wire jch_pkg::t_dp_status i_status,
    output logic                    o_in_stall,
    output jch_pkg::t_dp_cmd        o_cmd,
    output logic                    o_out_load
);
    import jch_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_KEY,
        S_DINIT,
        S_DIV,
        S_TEST,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   n_busy;
    logic   accept;

    assign accept = i_in_valid && !r_busy;

    always_comb begin
        n_state          = r_state;
        o_cmd.key_load   = 1'b0;
        o_cmd.key_update = 1'b0;
        o_cmd.mul_sel    = MUL_LO_LO;
        o_cmd.acc_op     = ACC_HOLD;
        o_cmd.div_init   = 1'b0;
        o_cmd.div_step   = 1'b0;
        o_cmd.b_load     = 1'b0;
        o_out_load       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.key_load = 1'b1;
                    n_state = i_status.count_zero ? S_DONE : S_MUL0;
                end
            end
            S_MUL0: begin
                o_cmd.mul_sel = MUL_LO_LO;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul_sel = MUL_LO_HI;
                o_cmd.acc_op  = ACC_LOAD;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_sel = MUL_HI_LO;
                o_cmd.acc_op  = ACC_ADD_HI;
                n_state = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.acc_op = ACC_ADD_HI;
                n_state = S_KEY;
            end
            S_KEY: begin
                o_cmd.key_update = 1'b1;
                n_state = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (i_status.more) begin
                    o_cmd.b_load = 1'b1;
                    n_state = S_MUL0;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_in_stall = r_busy;

endmodule

`default_nettype wire

// File: hw/rtl/jump_consistent_hash_core.sv
// Each jump step runs the 64-bit key update on one shared 32x32 multiplier (states S_MUL0
// to S_MUL3), the key write-back, the divider setup, the bit-serial divider and the loop
// test. A zero bucket count skips the jump steps and answers 0. One key is processed at
// a time; a new key is taken while the previous result waits in the output register.
// Reset (synchronous, active low) empties the block, sets bucket_count to 1 and the multiplier.
`default_nettype none

module jump_consistent_hash_core #(
    parameter int BUCKET_BITS = jch_pkg::BUCKET_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Key channel.
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [jch_pkg::KEY_W-1:0]      i_hash_key,
    // Bucket channel.
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [jch_pkg::BUCKET_W-1:0]        o_bucket_index,
    // Configuration write channel.
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [jch_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [jch_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import jch_pkg::*;

    // Configuration registers. Only the low BUCKET_BITS bits of the bucket count are kept,
    // which also bounds every bucket number the loop can produce.
    logic [BUCKET_BITS-1:0] r_count;
    logic [KEY_W-1:0]       r_mult;

    // Output register. It decouples the result from the key side, so the next key
    // transfer can happen while a finished bucket still waits for its consumer.
    logic                   r_o_valid;
    logic [BUCKET_W-1:0]    r_o_bucket;

    t_dp_cmd                dp_cmd;
    t_dp_status             dp_status;
    logic [BUCKET_BITS-1:0] dp_bucket;
    logic                   out_load;
    logic                   out_free;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET[BUCKET_BITS-1:0];
            r_mult  <= MULT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BUCKET_COUNT: r_count <= i_cfg_data[BUCKET_BITS-1:0];
                CFG_LCG_MULT:     r_mult  <= i_cfg_data;
                default:          r_count <= r_count;
            endcase
        end
    end

    // The output slot is free when it is empty or its bucket transfers in this cycle.
    assign out_free = !r_o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_bucket <= BUCKET_W'(dp_bucket);
        end
    end

    assign o_valid        = r_o_valid;
    assign o_bucket_index = r_o_bucket;

    // The controller sequences the key update, the division and the loop test.
    jch_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_out_free (out_free),
        .i_status   (dp_status),
        .o_in_stall (o_stall),
        .o_cmd      (dp_cmd),
        .o_out_load (out_load)
    );

    // The datapath holds the key, the multiplier product, the divider and the current bucket.
    jch_datapath #(
        .BUCKET_BITS (BUCKET_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_key    (i_hash_key),
        .i_mult   (r_mult),
        .i_count  (r_count),
        .i_cmd    (dp_cmd),
        .o_status (dp_status),
        .o_bucket (dp_bucket)
    );

`ifndef SYNTH
    // A waiting bucket always lies below the configured bucket count when that count is nonzero.
    a_bucket_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_count != '0)) |-> (r_o_bucket < BUCKET_W'(r_count)))
        else $error("bucket number not below bucket count");

    // A key transfer starts the work, so the key side stalls in the next cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("key side not stalled after a key transfer");

    // A result is written into the output register only when the slot is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_o_valid || !i_stall))
        else $error("pending bucket overwritten");
`endif

endmodule

`default_nettype wire

// File: verif/jch_bucket_checker.sv
`default_nettype none

module jch_bucket_checker #(
    parameter int BUCKET_BITS = jch_pkg::BUCKET_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire logic                           o_stall,
    input  wire logic [jch_pkg::KEY_W-1:0]      i_hash_key,
    input  wire logic                           o_valid,
    input  wire logic                           i_stall,
    input  wire logic [jch_pkg::BUCKET_W-1:0]   o_bucket_index,
    input  wire logic                           i_cfg_valid,
    input  wire logic                           o_cfg_ready,
    input  wire logic [jch_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [jch_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import jch_pkg::*;

    logic [BUCKET_W-1:0] bucket_count;
    logic [KEY_W-1:0]    lcg_mult;
    logic [BUCKET_W-1:0] pending_buckets[$];
    int                  mismatches;

    function automatic logic [63:0] bucket_mask();
        return (64'd1 << BUCKET_BITS) - 64'd1;
    endfunction

    // Jump consistent hash with exact integer division.
    function automatic logic [BUCKET_W-1:0] jump_bucket(logic [KEY_W-1:0] key,
                                                        logic [BUCKET_W-1:0] count,
                                                        logic [KEY_W-1:0] mult);
        logic [63:0] limit;
        logic [63:0] last;
        logic [63:0] next;
        logic [63:0] divisor;
        limit = {32'd0, count} & bucket_mask();
        last  = '0;
        next  = '0;
        while (next < limit) begin
            last    = next;
            key     = key * mult + 64'd1;
            divisor = (key >> KEY_SHIFT) + 64'd1;
            next    = ((last + 64'd1) << FRAC_SHIFT) / divisor;
        end
        return BUCKET_W'(last & bucket_mask());
    endfunction

    always @(posedge i_clk) begin
        logic [BUCKET_W-1:0] want;
        if (!i_rst_n) begin
            bucket_count = COUNT_RESET;
            lcg_mult     = MULT_RESET;
            pending_buckets.delete();
            mismatches   = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_BUCKET_COUNT: begin
                        bucket_count = BUCKET_W'(i_cfg_data[31:0] & bucket_mask());
                    end
                    CFG_LCG_MULT: begin
                        lcg_mult = i_cfg_data;
                    end
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                pending_buckets.insert(pending_buckets.size(),
                                       jump_bucket(i_hash_key, bucket_count, lcg_mult));
            end
            if (o_valid && !i_stall) begin
                if (pending_buckets.size() == 0) begin
                    $error("bucket_index: result %0d arrived with nothing expected",
                           o_bucket_index);
                    mismatches++;
                end else begin
                    want = pending_buckets.pop_front();
                    if (want !== o_bucket_index) begin
                        $error("bucket_index: expected %0d, actual %0d", want, o_bucket_index);
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count  <= mismatches;
        o_outstanding <= pending_buckets.size();
    end

endmodule

`default_nettype wire

// File: verif/jump_consistent_hash_core_test.sv
`default_nettype none

module jump_consistent_hash_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import jch_pkg::*;

    // Least number of random keys to send after the directed part.
    localparam int RANDOM_KEYS = 930;
    // Cycles to let pass after the last bucket transfer before touching registers.
    localparam int SETTLE_CYCLES = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  key_valid;
    logic                  key_stall;
    logic [KEY_W-1:0]      hash_key;
    logic                  bucket_valid;
    logic                  bucket_stall = 1'b0;
    logic [BUCKET_W-1:0]   bucket_index;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int outstanding;

    // When cleared, neither the key sender nor the bucket receiver starts a new gap.
    bit          idle_on = 1'b1;
    int unsigned stall_left = 0;

    int unsigned keys_sent = 0;
    int unsigned settings_seen = 0;
    logic [31:0] widest_count = '0;

    jump_consistent_hash_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (key_valid),
        .o_stall        (key_stall),
        .i_hash_key     (hash_key),
        .o_valid        (bucket_valid),
        .i_stall        (bucket_stall),
        .o_bucket_index (bucket_index),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    // The checker sees every transfer on all three channels, keeps its own copy of the
    // registers and compares each bucket with the prediction made when its key went in.
    jch_bucket_checker checker_inst (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (key_valid),
        .o_stall        (key_stall),
        .i_hash_key     (hash_key),
        .o_valid        (bucket_valid),
        .i_stall        (bucket_stall),
        .o_bucket_index (bucket_index),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // A hard stop in case the block hangs. It lies far beyond the time a correct run needs,
    // even if every key took the most jump steps the stimulus allows, under the longest
    // stalls.
    initial begin
        #200_000_000;
        $display("simulation failed");
        $finish;
    end

    // Idle lengths: mostly short, now and then a long pause.
    function automatic int unsigned pick_len();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    // The bucket receiver alternates between runs of stalling and runs of taking
    // every transfer. With idling switched off it starts no new run of stalling.
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left--;
        end else if (idle_on && $urandom_range(0, 2) == 0) begin
            bucket_stall <= 1'b1;
            stall_left = pick_len() - 1;
        end else begin
            bucket_stall <= 1'b0;
            stall_left = idle_on ? $urandom_range(0, 6) : 0;
        end
    end

    // Keys: mostly fully random, with the corners mixed in so every bit
    // sees both values often.
    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return 64'(1) << $urandom_range(0, 63);
            3:       return ~(64'(1) << $urandom_range(0, 63));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Bucket counts spread over every order of magnitude, so the number of jump steps
    // (and thus the latency) varies widely while the average run stays short.
    function automatic logic [31:0] rand_count();
        if ($urandom_range(0, 15) == 0) begin
            return '1;
        end
        return $urandom >> $urandom_range(0, 31);
    endfunction

    // Presents one key and holds it until the block takes the transfer. The task
    // returns right after the edge at which the transfer happened.
    task automatic send_key(input logic [KEY_W-1:0] key);
        key_valid <= 1'b1;
        hash_key  <= key;
        do @(posedge clk); while (key_stall);
        keys_sent++;
    endtask

    // Optional pause after a key transfer. With no pause valid stays high, so the
    // next key follows back to back.
    task automatic key_gap();
        int unsigned n;
        n = (idle_on && $urandom_range(0, 1) == 0) ? pick_len() : 0;
        if (n != 0) begin
            key_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Waits until every bucket has come back and the block has settled.
    task automatic drain();
        key_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Holds the write until the register port accepts it. Valid is left high so a
    // second write can follow directly; the caller lowers it.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Drains the block, then writes both registers in random order.
    task automatic apply_setting(input logic [31:0] count, input logic [KEY_W-1:0] mult);
        drain();
        if ($urandom_range(0, 1) == 0) begin
            write_reg(CFG_BUCKET_COUNT, {32'd0, count});
            write_reg(CFG_LCG_MULT, mult);
        end else begin
            write_reg(CFG_LCG_MULT, mult);
            write_reg(CFG_BUCKET_COUNT, {32'd0, count});
        end
        cfg_valid <= 1'b0;
        settings_seen++;
        if (count > widest_count) begin
            widest_count = count;
        end
    endtask

    task automatic send_list(input logic [KEY_W-1:0] keys[$]);
        foreach (keys[k]) begin
            send_key(keys[k]);
            key_gap();
        end
    endtask

    initial begin
        logic [31:0]      count;
        logic [KEY_W-1:0] mult;
        int unsigned      batch;
        int unsigned      random_sent;

        key_valid <= 1'b0;
        hash_key  <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_BUCKET_COUNT;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n     <= 1'b1;
        @(posedge clk);

        // Directed part. First the reset settings: one bucket, so every key maps to 0.
        send_list('{64'd0, '1, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555,
                    64'hAAAA_AAAA_AAAA_AAAA, 64'd1});

        // A zero bucket count never enters the loop and answers 0.
        apply_setting(32'd0, MULT_RESET);
        send_list('{64'd0, '1});

        // The widest bucket count takes the most jump steps.
        apply_setting('1, MULT_RESET);
        send_list('{64'd0, '1, 64'h5555_5555_5555_5555, {$urandom, $urandom}});

        apply_setting(32'd2, MULT_RESET);
        send_list('{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210});

        // Degenerate multipliers: a zero multiplier makes the key constant, a unit
        // multiplier only counts it up, and all ones makes it flip between two values.
        // A unit multiplier can walk one bucket per step, so the counts stay small.
        apply_setting(32'd1000, 64'd0);
        send_list('{64'd0, '1});
        apply_setting(32'd40, 64'd1);
        send_list('{64'd0, 64'hFFFF_FFFE_0000_0000, '1});
        apply_setting(32'd40, '1);
        send_list('{64'd0, 64'h7FFF_FFFF_FFFF_FFFF});

        // Random part: settings change every few dozen keys. Half of the settings use the
        // standard multiplier, most of the rest a random one and the others a degenerate one.
        random_sent = 0;
        while (random_sent < RANDOM_KEYS) begin
            case ($urandom_range(0, 19))
                17:      mult = '0;
                18:      mult = 64'd1;
                19:      mult = '1;
                default: begin
                    mult = ($urandom_range(0, 16) < 10) ? MULT_RESET : {$urandom, $urandom};
                end
            endcase
            count = (mult inside {64'd0, 64'd1, '1}) ? $urandom_range(0, 64) : rand_count();
            apply_setting(count, mult);

            // Roughly one setting in four runs with no idling on either side.
            idle_on = ($urandom_range(0, 3) != 0);
            batch = $urandom_range(40, 110);
            repeat (batch) begin
                send_key(rand_key());
                key_gap();
            end
            random_sent += batch;
        end

        idle_on = 1'b1;
        drain();

        $display("Sent %0d keys over %0d register settings, bucket counts up to %0d,",
                 keys_sent, settings_seen, widest_count);
        $display("with standard, random and degenerate multipliers and random idling.");
        if (fail_count == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/jch_pkg.sv
hw/rtl/jch_datapath.sv
hw/rtl/jch_ctrl.sv
hw/rtl/jump_consistent_hash_core.sv
verif/jch_bucket_checker.sv
verif/jump_consistent_hash_core_test.sv
